### rtl/core/tlfd_pkg.sv
// Shared types and constants of the typed-length frame deframer.
package tlfd_pkg;

  localparam int unsigned MaxFrameWidth = 16;
  localparam int unsigned TypeWidth     = 8;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned ApbDataWidth  = 32;
  localparam int unsigned ApbAddrWidth  = 3;

  localparam logic [MaxFrameWidth-1:0] MaxFrameReset = 16'd172;
  localparam logic [TypeWidth-1:0]     ExpTypeReset  = 8'h3c;

  typedef enum logic [0:0] {
    REG_MAX_FRAME = 1'b0,
    REG_EXP_TYPE  = 1'b1
  } reg_index_e;

  typedef enum logic [1:0] {
    EV_DATA       = 2'd0,
    EV_OVERSIZE   = 2'd1,
    EV_WRONG_TYPE = 2'd2,
    EV_ABORT      = 2'd3
  } event_e;

  typedef enum logic [0:0] {
    KIND_BYTE     = 1'b0,
    KIND_NEW_CONN = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [ByteWidth-1:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    event_e               event_res;
    logic [ByteWidth-1:0] data_byte;
    logic                 last;
  } out_word_t;

endpackage

### rtl/core/tlfd_if.sv
// Valid/ready channels for received words and deframer results.
interface tlfd_in_if;
  logic               valid;
  logic               ready;
  tlfd_pkg::in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tlfd_out_if;
  logic                valid;
  logic                ready;
  tlfd_pkg::out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/typed_length_frame_deframer.sv
// Typed-length frame deframer: header parser, payload pass/skip, result register.
//
// Usage:
//   in_i carries one word per handshake: kind (byte or new connection) and
//   rx_byte. out_o carries at most one result word per input word: a payload
//   byte with last on the final byte of a frame, or a skip/abort event.
//   Frames are a type byte, a 16-bit little-endian length, then the payload.
//   The APB port writes max_frame_bytes (0x0) and expected_type (0x4); write
//   it only while no word is in flight.
// Pipeline and throughput:
//   An accepted word is held in the input register, where the header parser
//   updates its state; its result is then written to the output register,
//   which drives out_o.valid. One word per cycle is sustained: the input
//   register advances whenever the output register is empty or being taken.
// Reset: parser returns to awaiting a type byte, registers take their
//   defaults (172, 0x3c), both pipeline registers empty.
// Stall: when out_o.ready is low with a result held, the input register
//   holds one more word and then in_i.ready drops until the result is taken.
module typed_length_frame_deframer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  tlfd_in_if.sink                            in_i,
  tlfd_out_if.source                         out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tlfd_pkg::ApbAddrWidth-1:0]  paddr,
  input  logic [tlfd_pkg::ApbDataWidth-1:0]  pwdata,
  output logic [tlfd_pkg::ApbDataWidth-1:0]  prdata,
  output logic                               pready
);

  localparam logic [2:0] PH_TYPE   = 3'd0;
  localparam logic [2:0] PH_LEN_LO = 3'd1;
  localparam logic [2:0] PH_LEN_HI = 3'd2;
  localparam logic [2:0] PH_PASS   = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  localparam int unsigned LenW  = tlfd_pkg::MaxFrameWidth;
  localparam int unsigned ByteW = tlfd_pkg::ByteWidth;

  // Configuration registers
  logic [LenW-1:0]                 max_frame_q;
  logic [tlfd_pkg::TypeWidth-1:0]  exp_type_q;
  tlfd_pkg::reg_index_e            reg_idx;
  logic                            cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = tlfd_pkg::reg_index_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= tlfd_pkg::MaxFrameReset;
      exp_type_q  <= tlfd_pkg::ExpTypeReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tlfd_pkg::REG_MAX_FRAME: max_frame_q <= pwdata[LenW-1:0];
        tlfd_pkg::REG_EXP_TYPE:  exp_type_q  <= pwdata[tlfd_pkg::TypeWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tlfd_pkg::REG_MAX_FRAME:
        prdata = {{(tlfd_pkg::ApbDataWidth-LenW){1'b0}}, max_frame_q};
      tlfd_pkg::REG_EXP_TYPE:
        prdata = {{(tlfd_pkg::ApbDataWidth-tlfd_pkg::TypeWidth){1'b0}}, exp_type_q};
      default: prdata = '0;
    endcase
  end

  // Input register
  logic               in_valid_q;
  tlfd_pkg::in_word_t in_word_q;
  logic               out_valid_q;
  tlfd_pkg::out_word_t out_word_q;
  logic               stage_go;

  // Advance the input register when the output register can take its result.
  assign stage_go   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || stage_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_word_q <= in_i.payload;
    end
  end

  // Parser state
  logic [2:0]               phase_q, phase_d;
  logic [ByteW-1:0]         held_type_q, held_type_d;
  logic [ByteW-1:0]         len_lo_q, len_lo_d;
  logic [LenW-1:0]          left_q, left_d;
  logic                     res_valid;
  tlfd_pkg::out_word_t      res_word;
  logic [LenW-1:0]          hdr_len;

  assign hdr_len = {in_word_q.rx_byte, len_lo_q};

  always_comb begin
    phase_d     = phase_q;
    held_type_d = held_type_q;
    len_lo_d    = len_lo_q;
    left_d      = left_q;
    res_valid   = 1'b0;
    res_word    = '{event_res: tlfd_pkg::EV_DATA, data_byte: '0, last: 1'b0};

    if (in_word_q.kind == tlfd_pkg::KIND_NEW_CONN) begin
      // Drop all header state; report an abort if a frame was open.
      res_valid          = (phase_q >= PH_LEN_LO) && (phase_q <= PH_SKIP);
      res_word.event_res = tlfd_pkg::EV_ABORT;
      phase_d            = PH_TYPE;
      held_type_d        = '0;
      len_lo_d           = '0;
      left_d             = '0;
    end else begin
      unique case (phase_q)
        PH_LEN_LO: begin
          len_lo_d = in_word_q.rx_byte;
          phase_d  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (held_type_q == '0 || hdr_len == '0) begin
            phase_d     = PH_TYPE;
            held_type_d = '0;
            len_lo_d    = '0;
            left_d      = '0;
          end else begin
            left_d = hdr_len;
            // Oversize wins over a type mismatch.
            priority if (hdr_len > max_frame_q) begin
              phase_d            = PH_SKIP;
              res_valid          = 1'b1;
              res_word.event_res = tlfd_pkg::EV_OVERSIZE;
            end else if (held_type_q != exp_type_q) begin
              phase_d            = PH_SKIP;
              res_valid          = 1'b1;
              res_word.event_res = tlfd_pkg::EV_WRONG_TYPE;
            end else begin
              phase_d = PH_PASS;
            end
          end
        end
        PH_PASS, PH_SKIP: begin
          if (left_q <= LenW'(1)) begin
            phase_d     = PH_TYPE;
            held_type_d = '0;
            len_lo_d    = '0;
            left_d      = '0;
          end else begin
            left_d = left_q - LenW'(1);
          end
          if (phase_q == PH_PASS) begin
            res_valid          = 1'b1;
            res_word.data_byte = in_word_q.rx_byte;
            res_word.last      = (left_q <= LenW'(1));
          end
        end
        default: begin
          // Awaiting type; unused codes fall here too.
          held_type_d = in_word_q.rx_byte;
          len_lo_d    = '0;
          left_d      = '0;
          phase_d     = PH_LEN_LO;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TYPE;
      held_type_q <= '0;
      len_lo_q    <= '0;
      left_q      <= '0;
    end else if (stage_go) begin
      phase_q     <= phase_d;
      held_type_q <= held_type_d;
      len_lo_q    <= len_lo_d;
      left_q      <= left_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_go) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_go && res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_word_q;

`ifndef SYNTHESIS
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_SKIP)
    else $error("parser phase out of range");

  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PASS || phase_q == PH_SKIP) |-> left_q != '0)
    else $error("payload phase with no bytes left");

  a_new_conn_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_go && in_word_q.kind == tlfd_pkg::KIND_NEW_CONN |=> phase_q == PH_TYPE)
    else $error("new connection did not clear parser");

  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.last |-> out_word_q.event_res == tlfd_pkg::EV_DATA)
    else $error("last marker on a non-data result");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_go && res_valid && res_word.last |=> phase_q == PH_TYPE)
    else $error("frame did not close after last byte");
`endif

endmodule
